// ===== src/acpu_pkg.sv =====
// Package for the accumulator CPU execute block: payload types, opcodes, status codes.
`default_nettype none
package acpu_pkg;

  // Default sizes of the data and program spaces
  localparam int DATA_WORDS_DEF    = 256;
  localparam int PROGRAM_WORDS_DEF = 1024;

  // Opcodes
  localparam logic [3:0] OP_LOAD   = 4'd1;
  localparam logic [3:0] OP_STORE  = 4'd2;
  localparam logic [3:0] OP_ADD    = 4'd3;
  localparam logic [3:0] OP_SUB    = 4'd4;
  localparam logic [3:0] OP_INPUT  = 4'd5;
  localparam logic [3:0] OP_OUTPUT = 4'd6;
  localparam logic [3:0] OP_JMP    = 4'd7;
  localparam logic [3:0] OP_JPOS   = 4'd8;
  localparam logic [3:0] OP_JNEG   = 4'd9;
  localparam logic [3:0] OP_JZERO  = 4'd10;
  localparam logic [3:0] OP_HALT   = 4'd11;

  // Status codes
  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_HALT    = 2'd1;
  localparam logic [1:0] ST_ILLEGAL = 2'd2;

  // One instruction
  typedef struct packed {
    logic [3:0]         op;
    logic [7:0]         data_address;
    logic signed [31:0] input_word;
  } in_item_t;

  // One result
  typedef struct packed {
    logic [9:0]         next_pc;
    logic signed [31:0] output_word;
    logic               output_valid;
    logic [1:0]         status;
  } out_item_t;

  // Data memory write-back request
  typedef struct packed {
    logic        mem_we;
    logic [31:0] mem_wdata;
  } wb_t;

endpackage
`default_nettype wire

// ===== src/acpu_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module acpu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, then registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== src/acpu_exec.sv =====
// Execute unit: decodes one instruction and computes next machine state and result.
`default_nettype none
module acpu_exec #(
  parameter int PROGRAM_WORDS = acpu_pkg::PROGRAM_WORDS_DEF
) (
  input  wire logic [3:0]                     op,
  input  wire logic [31:0]                    mem_word,
  input  wire logic [31:0]                    acc,
  input  wire logic [$clog2(PROGRAM_WORDS)-1:0] pc,
  input  wire logic [1:0]                     stop,
  input  wire logic signed [31:0]             input_word,
  output logic      [31:0]                    acc_next,
  output logic      [$clog2(PROGRAM_WORDS)-1:0] pc_next,
  output logic      [1:0]                     stop_next,
  output acpu_pkg::wb_t                       wb,
  output acpu_pkg::out_item_t                 result
);
  import acpu_pkg::*;

  localparam int PCW = $clog2(PROGRAM_WORDS);

  logic [PCW-1:0] hi_mod [64];
  logic [PCW:0]   tgt_sum;
  logic [PCW-1:0] target;
  logic [PCW-1:0] pc_inc;
  logic           neg;
  logic           zero;
  logic           take;

  // Table of (upper six target bits * 16) mod program size
  for (genvar g = 0; g < 64; g++) begin : g_hi_mod
    assign hi_mod[g] = PCW'((g * 16) % PROGRAM_WORDS);
  end

  // Reduce the low 10 bits of the memory word to a program address
  always_comb begin
    tgt_sum = {1'b0, hi_mod[mem_word[9:4]]} + (PCW + 1)'(mem_word[3:0]);
    if (tgt_sum >= (PCW + 1)'(PROGRAM_WORDS)) begin
      target = PCW'(tgt_sum - (PCW + 1)'(PROGRAM_WORDS));
    end else begin
      target = PCW'(tgt_sum);
    end
  end

  // Sequential step with wrap at the top of program space
  assign pc_inc = (pc == PCW'(PROGRAM_WORDS - 1)) ? '0 : pc + PCW'(1);

  assign neg  = acc[31];
  assign zero = (acc == 32'd0);

  // Decode and execute
  always_comb begin
    acc_next      = acc;
    stop_next     = stop;
    wb.mem_we     = 1'b0;
    wb.mem_wdata  = acc;
    take          = 1'b0;
    result.output_word  = '0;
    result.output_valid = 1'b0;
    if (stop == ST_RUN) begin
      case (op)
        OP_LOAD:   acc_next = mem_word;
        OP_STORE:  wb.mem_we = 1'b1;
        OP_ADD:    acc_next = acc + mem_word;
        OP_SUB:    acc_next = acc - mem_word;
        OP_INPUT: begin
          wb.mem_we    = 1'b1;
          wb.mem_wdata = input_word;
        end
        OP_OUTPUT: begin
          result.output_word  = mem_word;
          result.output_valid = 1'b1;
        end
        OP_JMP:    take = 1'b1;
        OP_JPOS:   take = !neg && !zero;
        OP_JNEG:   take = neg;
        OP_JZERO:  take = zero;
        OP_HALT:   stop_next = ST_HALT;
        default:   stop_next = ST_ILLEGAL;
      endcase
      pc_next = take ? target : pc_inc;
    end else begin
      pc_next = pc;
    end
    result.next_pc = 10'(pc_next);
    result.status  = stop_next;
  end

endmodule
`default_nettype wire

// ===== src/accumulator_cpu_execute.sv =====
// Top level of the accumulator CPU execute block: read stage, execute/write-back stage, output register.
//
// Each transfer on the input channel carries one instruction; each produces exactly one result
// transfer. The block sustains one instruction per clock while the output register drains: the
// registered data memory read is issued in the cycle the instruction is taken, and the read stage
// then holds the instruction until the execute stage runs it, writes the memory word back and
// loads the output register. A write by one instruction is forwarded to the next one when they
// use the same word. Data memory words read as zero after reset through a per-word valid bit,
// so no clearing pass is needed and the block takes instructions as soon as reset is released.
// Once halted or stopped by an illegal opcode, every instruction returns the frozen program
// counter and status.
`default_nettype none
module accumulator_cpu_execute #(
  parameter int DATA_WORDS    = acpu_pkg::DATA_WORDS_DEF,
  parameter int PROGRAM_WORDS = acpu_pkg::PROGRAM_WORDS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire acpu_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output acpu_pkg::out_item_t      out_item
);
  import acpu_pkg::*;

  localparam int AW  = $clog2(DATA_WORDS);
  localparam int PCW = $clog2(PROGRAM_WORDS);

  logic [AW-1:0]         addr_hi [16];
  logic [AW:0]           addr_sum;
  logic [AW-1:0]         rd_addr;
  logic                  in_xfer;
  logic                  s1_advance;

  logic                  s1_valid;
  logic [3:0]            s1_op;
  logic [AW-1:0]         s1_addr;
  logic signed [31:0]    s1_word;
  logic                  fwd_hit;
  logic [31:0]           fwd_data;
  logic                  rd_vld;
  logic [31:0]           rd_data;
  logic [31:0]           mem_word;
  logic [DATA_WORDS-1:0] mem_vld;

  logic [31:0]           acc;
  logic [PCW-1:0]        pc;
  logic [1:0]            stop;
  logic [31:0]           acc_next;
  logic [PCW-1:0]        pc_next;
  logic [1:0]            stop_next;
  wb_t                   wb;
  out_item_t             result;

  // Table of (upper address nibble * 16) mod data size
  for (genvar g = 0; g < 16; g++) begin : g_addr_hi
    assign addr_hi[g] = AW'((g * 16) % DATA_WORDS);
  end

  // Reduce the data address into the data memory
  always_comb begin
    addr_sum = {1'b0, addr_hi[in_item.data_address[7:4]]} + (AW + 1)'(in_item.data_address[3:0]);
    if (addr_sum >= (AW + 1)'(DATA_WORDS)) begin
      rd_addr = AW'(addr_sum - (AW + 1)'(DATA_WORDS));
    end else begin
      rd_addr = AW'(addr_sum);
    end
  end

  // Handshake: execute stage moves on when the output register is free or drains
  assign s1_advance = s1_valid && (!out_valid || out_ready);
  assign in_ready   = !s1_valid || s1_advance;
  assign in_xfer    = in_valid && in_ready;

  acpu_ram #(
    .WIDTH (32),
    .DEPTH (DATA_WORDS)
  ) u_dmem (
    .clk   (clk),
    .we    (s1_advance && wb.mem_we),
    .waddr (s1_addr),
    .wdata (wb.mem_wdata),
    .re    (in_xfer),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  // Read stage: capture the instruction, valid bit and any same-word write in flight
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_xfer) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
    if (in_xfer) begin
      s1_op    <= in_item.op;
      s1_addr  <= rd_addr;
      s1_word  <= in_item.input_word;
      rd_vld   <= mem_vld[rd_addr];
      fwd_hit  <= s1_advance && wb.mem_we && (s1_addr == rd_addr);
      fwd_data <= wb.mem_wdata;
    end
  end

  // Select forwarded word, stored word, or zero for a never-written word
  assign mem_word = fwd_hit ? fwd_data : (rd_vld ? rd_data : 32'd0);

  acpu_exec #(
    .PROGRAM_WORDS (PROGRAM_WORDS)
  ) u_exec (
    .op         (s1_op),
    .mem_word   (mem_word),
    .acc        (acc),
    .pc         (pc),
    .stop       (stop),
    .input_word (s1_word),
    .acc_next   (acc_next),
    .pc_next    (pc_next),
    .stop_next  (stop_next),
    .wb         (wb),
    .result     (result)
  );

  // Execute stage: update machine state and valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      acc     <= '0;
      pc      <= '0;
      stop    <= ST_RUN;
      mem_vld <= '0;
    end else if (s1_advance) begin
      acc  <= acc_next;
      pc   <= pc_next;
      stop <= stop_next;
      if (wb.mem_we) begin
        mem_vld[s1_addr] <= 1'b1;
      end
    end
  end

  // Output register: load on advance, drop on transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
    if (s1_advance) begin
      out_item <= result;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_accumulator_cpu_execute.sv =====
// Testbench for accumulator_cpu_execute: directed program, random programs, stop and frozen tail.
module tb_accumulator_cpu_execute;
  timeunit 1ns;
  timeprecision 1ps;

  import acpu_pkg::*;

  localparam int CLK_HALF      = 10;
  localparam int RESET_CYCLES  = 10;
  localparam int RANDOM_ITEMS  = 960;
  localparam int HOLD_AT       = 760;
  localparam int HOLD_CYCLES   = 64;
  localparam int DRAIN_CYCLES  = 8;
  localparam int TIMEOUT_NS    = 5_000_000;
  localparam int PLAN_ROWS     = 23;

  // Opcodes outside the legal set
  localparam logic [3:0] OP_ZERO       = 4'd0;
  localparam logic [3:0] OP_ILLEGAL_LO = 4'd12;
  localparam logic [3:0] OP_ILLEGAL_HI = 4'd15;

  // Addresses and words that random programs favor, so words get reused
  localparam logic [7:0] ADDR_POOL [4] = '{8'd0, 8'd1, 8'd2, 8'd255};
  localparam logic [31:0] WORD_POOL [5] = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF,
                                            32'h7FFF_FFFF, 32'h8000_0000};

  typedef struct packed {
    in_item_t  ins;
    logic      has_want;
    out_item_t want;
  } plan_row_t;

  // Directed program; rows with has_want carry a hand-written result
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{OP_OUTPUT, 8'd0,   32'sh0000_0000}, 1'b1, '{10'd1,    32'sh0000_0000, 1'b1, ST_RUN}},
    '{'{OP_INPUT,  8'd255, 32'sh7FFF_FFFF}, 1'b1, '{10'd2,    32'sh0000_0000, 1'b0, ST_RUN}},
    '{'{OP_INPUT,  8'd0,   32'sh8000_0000}, 1'b1, '{10'd3,    32'sh0000_0000, 1'b0, ST_RUN}},
    '{'{OP_OUTPUT, 8'd255, 32'sh0000_0000}, 1'b1, '{10'd4,    32'sh7FFF_FFFF, 1'b1, ST_RUN}},
    '{'{OP_OUTPUT, 8'd0,   32'sh0000_0000}, 1'b1, '{10'd5,    32'sh8000_0000, 1'b1, ST_RUN}},
    '{'{OP_JZERO,  8'd255, 32'sh0000_0000}, 1'b1, '{10'd1023, 32'sh0000_0000, 1'b0, ST_RUN}},
    '{'{OP_LOAD,   8'd255, 32'sh0000_0000}, 1'b1, '{10'd0,    32'sh0000_0000, 1'b0, ST_RUN}},
    '{'{OP_ADD,    8'd255, 32'sh1234_5678}, 1'b0, '0},
    '{'{OP_JNEG,   8'd0,   32'sh0000_0000}, 1'b0, '0},
    '{'{OP_STORE,  8'd17,  32'shFFFF_FFFF}, 1'b0, '0},
    '{'{OP_SUB,    8'd17,  32'sh0000_0000}, 1'b0, '0},
    '{'{OP_JPOS,   8'd255, 32'sh0000_0000}, 1'b0, '0},
    '{'{OP_JNEG,   8'd255, 32'sh0000_0000}, 1'b0, '0},
    '{'{OP_INPUT,  8'd128, 32'sh0000_0155}, 1'b0, '0},
    '{'{OP_JMP,    8'd128, 32'sh0000_0000}, 1'b0, '0},
    '{'{OP_LOAD,   8'd0,   32'sh0000_0000}, 1'b0, '0},
    '{'{OP_SUB,    8'd255, 32'sh0000_0000}, 1'b0, '0},
    '{'{OP_JPOS,   8'd128, 32'sh0000_0000}, 1'b0, '0},
    '{'{OP_INPUT,  8'd64,  32'shFFFF_FFFF}, 1'b0, '0},
    '{'{OP_JMP,    8'd64,  32'sh0000_0000}, 1'b0, '0},
    '{'{OP_ADD,    8'd64,  32'sh0000_0000}, 1'b0, '0},
    '{'{OP_JZERO,  8'd17,  32'sh0000_0000}, 1'b0, '0},
    '{'{OP_OUTPUT, 8'd17,  32'sh0000_0000}, 1'b0, '0}
  };

  logic      clk = 1'b0;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_item;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_item;

  // Machine state as the testbench sees it
  logic [31:0] acc_model;
  logic [31:0] mem_model [256];
  logic [9:0]  pc_model;
  logic [1:0]  stop_model;

  out_item_t results_due [$];
  int        sent_count    = 0;
  int        checked_count = 0;
  int        output_count  = 0;
  int        fail_count    = 0;
  int        send_idle_pct = 15;
  int        recv_idle_pct = 76;

  accumulator_cpu_execute u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

  always #(CLK_HALF) clk = ~clk;

  // Execute one instruction on the machine state and return its result
  function automatic out_item_t execute_instr(input in_item_t ins);
    out_item_t   r;
    logic [31:0] word;
    logic [9:0]  pc_next;
    r = '0;
    if (stop_model == ST_RUN) begin
      word    = mem_model[ins.data_address];
      pc_next = pc_model + 10'd1;
      case (ins.op)
        OP_LOAD:   acc_model = word;
        OP_STORE:  mem_model[ins.data_address] = acc_model;
        OP_ADD:    acc_model = acc_model + word;
        OP_SUB:    acc_model = acc_model - word;
        OP_INPUT:  mem_model[ins.data_address] = ins.input_word;
        OP_OUTPUT: begin
          r.output_word  = word;
          r.output_valid = 1'b1;
        end
        OP_JMP:    pc_next = word[9:0];
        OP_JPOS:   if (!acc_model[31] && acc_model != 32'd0) pc_next = word[9:0];
        OP_JNEG:   if (acc_model[31]) pc_next = word[9:0];
        OP_JZERO:  if (acc_model == 32'd0) pc_next = word[9:0];
        OP_HALT:   stop_model = ST_HALT;
        default:   stop_model = ST_ILLEGAL;
      endcase
      pc_model = pc_next;
    end
    r.next_pc = pc_model;
    r.status  = stop_model;
    return r;
  endfunction

  // Legal instruction with operands biased toward a few shared words
  function automatic in_item_t random_instr();
    in_item_t ins;
    ins.op = 4'($urandom_range(OP_LOAD, OP_JZERO));
    if ($urandom_range(0, 99) < 60)
      ins.data_address = ADDR_POOL[$urandom_range(0, 3)];
    else
      ins.data_address = 8'($urandom_range(0, 255));
    if ($urandom_range(0, 99) < 25)
      ins.input_word = WORD_POOL[$urandom_range(0, 4)];
    else
      ins.input_word = $urandom();
    return ins;
  endfunction

  // Offer one instruction, hold it until the transfer, then record its result
  task automatic transfer_instr(input in_item_t ins, input out_item_t want);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= ins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    results_due.push_back(want);
    sent_count++;
  endtask

  // Stimulus: directed program, random programs, stop, frozen tail
  initial begin : stimulus
    in_item_t  ins;
    out_item_t pred;
    rst      = 1'b1;
    in_valid = 1'b0;
    in_item  = '0;
    acc_model  = '0;
    pc_model   = '0;
    stop_model = ST_RUN;
    foreach (mem_model[i]) mem_model[i] = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;

    foreach (PLAN[i]) begin
      pred = execute_instr(PLAN[i].ins);
      transfer_instr(PLAN[i].ins, PLAN[i].has_want ? PLAN[i].want : pred);
    end

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 3) begin
        send_idle_pct = 76;
        recv_idle_pct = 15;
      end else if (n == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      ins  = random_instr();
      pred = execute_instr(ins);
      transfer_instr(ins, pred);
    end

    // Stop the machine by halt, by opcode zero or by an opcode above halt
    ins = random_instr();
    case ($urandom_range(0, 2))
      0:       ins.op = OP_HALT;
      1:       ins.op = OP_ZERO;
      default: ins.op = 4'($urandom_range(OP_ILLEGAL_LO, OP_ILLEGAL_HI));
    endcase
    pred = execute_instr(ins);
    transfer_instr(ins, pred);

    // Every opcode once more against the stopped machine
    for (int k = 0; k < 16; k++) begin
      ins    = random_instr();
      ins.op = 4'(k);
      pred   = execute_instr(ins);
      transfer_instr(ins, pred);
    end
    in_valid <= 1'b0;

    while (results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d instructions (%0d directed, %0d random, 17 stop and stopped-state).",
             sent_count, PLAN_ROWS, RANDOM_ITEMS);
    $display("Checked %0d results, %0d of them output transfers; machine ended with status %0d.",
             checked_count, output_count, stop_model);
    if (fail_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Receiver: random back-pressure, one long hold-off to fill the block
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (!hold_done && sent_count >= HOLD_AT) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
      @(posedge clk);
    end
  end

  // Compare each result transfer with the oldest outstanding result
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (results_due.size() == 0) begin
        $error("result transfer with nothing outstanding: %p", out_item);
        fail_count++;
      end else begin
        want = results_due.pop_front();
        checked_count++;
        if (out_item.output_valid) output_count++;
        if (out_item.next_pc !== want.next_pc) begin
          $error("next_pc: expected %0d, got %0d", want.next_pc, out_item.next_pc);
          fail_count++;
        end
        if (out_item.output_word !== want.output_word) begin
          $error("output_word: expected %0d, got %0d", want.output_word, out_item.output_word);
          fail_count++;
        end
        if (out_item.output_valid !== want.output_valid) begin
          $error("output_valid: expected %0d, got %0d", want.output_valid, out_item.output_valid);
          fail_count++;
        end
        if (out_item.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_item.status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #(TIMEOUT_NS);
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
src/acpu_pkg.sv
src/acpu_ram.sv
src/acpu_exec.sv
src/accumulator_cpu_execute.sv
test/tb_accumulator_cpu_execute.sv
